// ===== rtl/sqrm_pkg.sv =====
// ----------------------------------------------------------------------------
// sqrm_pkg
// shared constants and types of the sorted quad run merger
// ----------------------------------------------------------------------------
package sqrm_pkg;
  localparam int unsigned MaxQuadsDef = 64;
  localparam int unsigned CoordW = 16;
  localparam int unsigned ExtW   = 17;
  localparam int unsigned KeyW   = 64;
  localparam int unsigned QuadW  = 4 * CoordW + 2 * ExtW;

  localparam logic [0:0] RegMergeAxis = 1'b0;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [ExtW-1:0]   w;
    logic [ExtW-1:0]   h;
    logic [CoordW-1:0] depth;
    logic [CoordW-1:0] kind;
  } quad_t;

  function automatic logic [KeyW-1:0] sort_key(input quad_t q, input logic axis);
    logic [CoordW-1:0] major;
    logic [CoordW-1:0] minor;
    major = axis ? q.x : q.y;
    minor = axis ? q.y : q.x;
    return {q.kind, q.depth, major, minor};
  endfunction
endpackage

// ===== rtl/sqrm_if.sv =====
// ----------------------------------------------------------------------------
// sqrm_in_if / sqrm_out_if
// valid/ready channels carrying input and result words
// ----------------------------------------------------------------------------
interface sqrm_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] quad_x;
  logic [15:0] quad_y;
  logic [15:0] quad_width;
  logic [15:0] quad_height;
  logic [15:0] quad_depth;
  logic [15:0] quad_kind;
  logic        last_quad;
  modport source (output valid, quad_x, quad_y, quad_width, quad_height, quad_depth,
                  quad_kind, last_quad, input ready);
  modport sink (input valid, quad_x, quad_y, quad_width, quad_height, quad_depth,
                quad_kind, last_quad, output ready);
endinterface

interface sqrm_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_x;
  logic [15:0] out_y;
  logic [16:0] out_width;
  logic [16:0] out_height;
  logic [15:0] out_depth;
  logic [15:0] out_kind;
  logic        out_last;
  modport source (output valid, out_x, out_y, out_width, out_height, out_depth,
                  out_kind, out_last, input ready);
  modport sink (input valid, out_x, out_y, out_width, out_height, out_depth,
                out_kind, out_last, output ready);
endinterface

// ===== rtl/sqrm_store.sv =====
// ----------------------------------------------------------------------------
// sqrm_store
// quad memory, one write and one registered read port
// ----------------------------------------------------------------------------
module sqrm_store
  import sqrm_pkg::*;
#(
  parameter int unsigned Depth = MaxQuadsDef,
  parameter int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  quad_t            wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output quad_t            rdata_o
);
  quad_t mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    // a read of the entry being written returns the new word
    if (we_i && waddr_i == raddr_i) begin
      rdata_o <= wdata_i;
    end else begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule

// ===== rtl/sorted_quad_run_merge.sv =====
// ----------------------------------------------------------------------------
// sorted_quad_run_merge
// collects a set of quads, sorts them stably and fuses abutting runs
// ----------------------------------------------------------------------------
// a word without last is taken in the cycle it is offered, one word per cycle
// a last word starts an in-place insertion sort: per quad a fetch, a compare, a
// shift and a re-read per entry shifted and a write, paced by the single read port
// of the quad memory; merging then fuses each abutting quad or emits a result word
// and waits for it to drain, and input waits until the set drains
// reset clears the control state and the fill count; the store needs no clear
module sorted_quad_run_merge
  import sqrm_pkg::*;
#(
  parameter int unsigned MaxQuads = MaxQuadsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  sqrm_in_if.sink     in_if,
  sqrm_out_if.source  out_if
);
  localparam int unsigned AddrW = $clog2(MaxQuads);
  localparam int unsigned CntW  = $clog2(MaxQuads + 1);
  localparam logic [CntW-1:0] Full = CntW'(MaxQuads);

  typedef enum logic [7:0] {
    S_LOAD   = 8'b0000_0001,
    S_SRD    = 8'b0000_0010, // read entry j-1 while inserting
    S_SCMP   = 8'b0000_0100, // compare and shift
    S_SINS   = 8'b0000_1000, // write the held key at its slot
    S_SNEXT  = 8'b0001_0000, // fetch the next element to insert
    S_MRD    = 8'b0010_0000, // take the first sorted entry
    S_MCMP   = 8'b0100_0000, // fuse or emit
    S_OUT    = 8'b1000_0000  // wait for the result word to drain
  } state_e;

  state_e          state_q, state_d;
  logic            axis_q;
  logic [CntW-1:0] fill_q, fill_d;
  logic [CntW-1:0] i_q, i_d;
  logic [CntW-1:0] j_q, j_d;
  quad_t           hold_q, hold_d;
  quad_t           cur_q, cur_d;
  logic            fin_q, fin_d;
  logic            ov_q, ov_d;
  quad_t           res_q, res_d;
  logic            rlast_q, rlast_d;

  logic            we;
  logic [AddrW-1:0] waddr, raddr;
  quad_t           wdata, rdata;

  // configuration port
  assign pready = 1'b1;
  assign prdata = {31'd0, axis_q};
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q <= 1'b0;
    end else if (psel && penable && pwrite && paddr == {RegMergeAxis, 1'b0}) begin
      axis_q <= pwdata[0];
    end
  end

  sqrm_store #(.Depth(MaxQuads), .AddrW(AddrW)) u_store (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata), .raddr_i(raddr), .rdata_o(rdata)
  );

  quad_t in_quad;
  always_comb begin
    in_quad.x     = in_if.quad_x;
    in_quad.y     = in_if.quad_y;
    in_quad.w     = {1'b0, in_if.quad_width};
    in_quad.h     = {1'b0, in_if.quad_height};
    in_quad.depth = in_if.quad_depth;
    in_quad.kind  = in_if.quad_kind;
  end

  assign in_if.ready = (state_q == S_LOAD);
  assign out_if.valid      = ov_q;
  assign out_if.out_x      = res_q.x;
  assign out_if.out_y      = res_q.y;
  assign out_if.out_width  = res_q.w;
  assign out_if.out_height = res_q.h;
  assign out_if.out_depth  = res_q.depth;
  assign out_if.out_kind   = res_q.kind;
  assign out_if.out_last   = rlast_q;

  logic fuse;
  always_comb begin
    if (!axis_q) begin
      fuse = (({1'b0, cur_q.x} + cur_q.w) == {1'b0, rdata.x}) && cur_q.y == rdata.y
             && cur_q.h == rdata.h;
    end else begin
      fuse = (({1'b0, cur_q.y} + cur_q.h) == {1'b0, rdata.y}) && cur_q.x == rdata.x
             && cur_q.w == rdata.w;
    end
    fuse = fuse && cur_q.depth == rdata.depth && cur_q.kind == rdata.kind;
  end

  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    i_d     = i_q;
    j_d     = j_q;
    hold_d  = hold_q;
    cur_d   = cur_q;
    fin_d   = fin_q;
    ov_d    = ov_q;
    res_d   = res_q;
    rlast_d = rlast_q;
    we      = 1'b0;
    waddr   = fill_q[AddrW-1:0];
    wdata   = in_quad;
    raddr   = '0;
    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      S_LOAD: begin
        if (in_if.valid) begin
          if (fill_q != Full) begin
            we     = 1'b1;
            fill_d = fill_q + 1'b1;
          end
          if (in_if.last_quad) begin
            i_d     = CntW'(1);
            raddr   = AddrW'(1);
            state_d = S_SNEXT;
          end
        end
      end
      S_SNEXT: begin
        // rdata holds entry i
        if (i_q >= fill_q) begin
          i_d     = CntW'(1);
          raddr   = '0;
          state_d = S_MRD;
        end else begin
          hold_d  = rdata;
          j_d     = i_q;
          raddr   = AddrW'(i_q - 1'b1);
          state_d = S_SCMP;
        end
      end
      S_SCMP: begin
        // rdata holds entry j-1
        if (sort_key(hold_q, axis_q) < sort_key(rdata, axis_q)) begin
          we      = 1'b1;
          waddr   = j_q[AddrW-1:0];
          wdata   = rdata;
          j_d     = j_q - 1'b1;
          if (j_q == CntW'(1)) begin
            state_d = S_SINS;
          end else begin
            raddr   = AddrW'(j_q - 2'd2);
            state_d = S_SRD;
          end
        end else begin
          state_d = S_SINS;
        end
      end
      S_SRD: begin
        state_d = S_SCMP;
        raddr   = AddrW'(j_q - 1'b1);
      end
      S_SINS: begin
        we      = 1'b1;
        waddr   = j_q[AddrW-1:0];
        wdata   = hold_q;
        i_d     = i_q + 1'b1;
        raddr   = AddrW'(i_q + 1'b1);
        state_d = S_SNEXT;
      end
      S_MRD: begin
        // rdata holds entry 0
        cur_d   = rdata;
        raddr   = AddrW'(1);
        state_d = S_MCMP;
      end
      S_MCMP: begin
        // rdata holds entry i
        raddr = AddrW'(i_q + 1'b1);
        if (i_q >= fill_q) begin
          res_d   = cur_q;
          rlast_d = 1'b1;
          fin_d   = 1'b1;
          state_d = S_OUT;
        end else if (fuse) begin
          if (!axis_q) cur_d.w = cur_q.w + rdata.w;
          else         cur_d.h = cur_q.h + rdata.h;
          i_d = i_q + 1'b1;
        end else begin
          res_d   = cur_q;
          rlast_d = 1'b0;
          cur_d   = rdata;
          i_d     = i_q + 1'b1;
          fin_d   = 1'b0;
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        raddr = AddrW'(i_q);
        if (!ov_q || out_if.ready) begin
          if (ov_q == 1'b0) begin
            ov_d = 1'b1;
          end
        end
        if (ov_q && out_if.ready) begin
          if (fin_q) begin
            fill_d  = '0;
            state_d = S_LOAD;
          end else begin
            state_d = S_MCMP;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      fill_q  <= '0;
      ov_q    <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      fin_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      ov_q    <= ov_d;
      i_q     <= i_d;
      j_q     <= j_d;
      fin_q   <= fin_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_q  <= hold_d;
    cur_q   <= cur_d;
    res_q   <= res_d;
    rlast_q <= rlast_d;
  end
endmodule
